FILE: rtl/core/floor_mat_button_serial_port_defines.svh
// Assertion macros for the floor mat button port.
// Depends on nothing; included by the checker.
`ifndef FLOOR_MAT_BUTTON_SERIAL_PORT_DEFINES_SVH
`define FLOOR_MAT_BUTTON_SERIAL_PORT_DEFINES_SVH

// Clocked assertion with asynchronous active-low reset.
`define FMBSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Same on the default clock and reset names.
`define FMBSP_ASSERT_DEF(lbl, prop, msg) `FMBSP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/core/fmbsp_pkg.sv
// Types, codes, constants and mask tables of the floor mat button port.
// Depends on nothing; used by the core and the top level.
`timescale 1ns / 1ps

package fmbsp_pkg;

  typedef enum logic [1:0] {
    OP_BUTTON = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  localparam logic CFG_DEVICE_KIND = 1'b0;
  localparam logic CFG_MAT_SIDE    = 1'b1;

  localparam logic KIND_SERIAL  = 1'b0;
  localparam logic SIDE_A       = 1'b0;

  localparam logic [31:0] LATCH_FILL  = 32'hffffaa00;
  localparam logic [1:0]  SHIFT_FILL  = 2'b11;
  localparam logic [2:0]  ROW_INVERT  = 3'h7;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0f;
  localparam logic [3:0]  SIDE_A_XOR  = 4'h3;
  localparam logic [3:0]  NUM_BUTTONS = 4'd12;

  typedef struct packed {
    logic [1:0] operation;
    logic       pressed;
    logic [3:0] button_number;
    logic [7:0] write_data;
    logic       port_number;
  } item_t;

  typedef struct packed {
    logic device_kind;
    logic mat_side;
  } cfg_t;

  function automatic logic [15:0] serial_mask(input logic [3:0] idx);
    logic [15:0] m;
    case (idx)
      4'd0:    m = 16'h0004;
      4'd1:    m = 16'h0001;
      4'd2:    m = 16'h0008;
      4'd3:    m = 16'h0002;
      4'd4:    m = 16'h0010;
      4'd5:    m = 16'h0100;
      4'd6:    m = 16'h4000;
      4'd7:    m = 16'h0080;
      4'd8:    m = 16'h0040;
      4'd9:    m = 16'h0400;
      4'd10:   m = 16'h1000;
      4'd11:   m = 16'h0020;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] rowscan_mask(input logic [3:0] idx);
    logic [15:0] m;
    case (idx)
      4'd0:    m = 16'h0008;
      4'd1:    m = 16'h0004;
      4'd2:    m = 16'h0002;
      4'd3:    m = 16'h0001;
      4'd4:    m = 16'h0080;
      4'd5:    m = 16'h0040;
      4'd6:    m = 16'h0020;
      4'd7:    m = 16'h0010;
      4'd8:    m = 16'h0800;
      4'd9:    m = 16'h0400;
      4'd10:   m = 16'h0200;
      4'd11:   m = 16'h0100;
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/fmbsp_core.sv
// Button register, shift latch and strobe state with their update logic.
// Depends on fmbsp_pkg.
`timescale 1ns / 1ps

module fmbsp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  fmbsp_pkg::item_t    item_i,
  input  fmbsp_pkg::cfg_t     cfg_i,
  output logic [7:0]          read_data_o
);
  import fmbsp_pkg::*;

  logic [15:0] pressed_mask_q, pressed_mask_d;
  logic [31:0] shift_latch_q, shift_latch_d;
  logic        strobe_high_q, strobe_high_d;

  logic [3:0]  idx;
  logic [15:0] mask;
  logic [2:0]  sel;
  logic [3:0]  nibble;
  logic [7:0]  inv;

  always_comb begin
    idx = item_i.button_number - 4'd1;
    if (cfg_i.mat_side == SIDE_A) begin
      idx = idx ^ SIDE_A_XOR;
    end
    mask = (cfg_i.device_kind == KIND_SERIAL) ? serial_mask(idx) : rowscan_mask(idx);

    sel = item_i.write_data[2:0] ^ ROW_INVERT;
    if (sel[0]) begin
      nibble = pressed_mask_q[11:8];
    end else if (sel[1]) begin
      nibble = pressed_mask_q[7:4];
    end else begin
      nibble = pressed_mask_q[3:0];
    end

    inv = shift_latch_q[7:0] ^ NIBBLE_MASK;

    pressed_mask_d = pressed_mask_q;
    shift_latch_d  = shift_latch_q;
    strobe_high_d  = strobe_high_q;
    read_data_o    = 8'h00;

    case (item_i.operation)
      OP_BUTTON: begin
        if (idx < NUM_BUTTONS) begin
          pressed_mask_d = item_i.pressed ? (pressed_mask_q | mask)
                                          : (pressed_mask_q & ~mask);
        end
      end
      OP_WRITE: begin
        if (cfg_i.device_kind == KIND_SERIAL) begin
          if (!strobe_high_q && item_i.write_data[0]) begin
            strobe_high_d = 1'b1;
          end else if (strobe_high_q && !item_i.write_data[0]) begin
            strobe_high_d = 1'b0;
            shift_latch_d = LATCH_FILL | {16'h0000, pressed_mask_q};
          end
        end else begin
          shift_latch_d = {28'h0000000, nibble};
        end
      end
      OP_READ: begin
        if (cfg_i.device_kind == KIND_SERIAL) begin
          read_data_o   = {3'b000, shift_latch_q[1:0], 3'b000};
          shift_latch_d = {SHIFT_FILL, shift_latch_q[31:2]};
        end else if (item_i.port_number) begin
          read_data_o = {inv[6:0], 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_mask_q <= '0;
      shift_latch_q  <= '0;
      strobe_high_q  <= 1'b0;
    end else if (step_i) begin
      pressed_mask_q <= pressed_mask_d;
      shift_latch_q  <= shift_latch_d;
      strobe_high_q  <= strobe_high_d;
    end
  end

endmodule

FILE: rtl/core/floor_mat_button_serial_port.sv
// Top level of the floor mat button port: input register, result register, config.
// Depends on fmbsp_pkg and fmbsp_core.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   operation, pressed, button_number,
//                                                 write_data, port_number
//   out      output     out_valid_o / out_stall_i read_data
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_wdata_i
//
// One item per cycle while in_stall_o is low; a read's result is registered as the read steps.
// State updates happen as an item leaves the input register.
// A read item holds in the input register only while the result register is full and stalled.
// Reset clears the button register, shift latch, strobe and both config registers.
`timescale 1ns / 1ps

module floor_mat_button_serial_port (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic       pressed_i,
  input  logic [3:0] button_number_i,
  input  logic [7:0] write_data_i,
  input  logic       port_number_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic       cfg_wdata_i
);
  import fmbsp_pkg::*;

  logic        in_valid_q;
  item_t       item_q;
  cfg_t        cfg_q;
  logic        out_valid_q;
  logic [7:0]  read_data_q;
  logic [7:0]  read_data_d;
  logic        is_read;
  logic        out_free;
  logic        step;
  logic        in_accept;

  assign is_read   = (item_q.operation == OP_READ);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign step      = in_valid_q && (!is_read || out_free);
  assign in_stall_o = in_valid_q && !step;
  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= '{operation: operation_i, pressed: pressed_i,
                  button_number: button_number_i, write_data: write_data_i,
                  port_number: port_number_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DEVICE_KIND: cfg_q.device_kind <= cfg_wdata_i;
        CFG_MAT_SIDE:    cfg_q.mat_side    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  fmbsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .read_data_o (read_data_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && is_read) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && is_read) begin
      read_data_q <= read_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

endmodule

FILE: rtl/core/fmbsp_checker.sv
// Port-level checks for the floor mat button port, bound to the top level.
// Depends on floor_mat_button_serial_port_defines.svh.
`timescale 1ns / 1ps
`include "floor_mat_button_serial_port_defines.svh"

module fmbsp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic       cfg_ready_o
);

  `FMBSP_ASSERT_DEF(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o), "stalled result item changed")
  `FMBSP_ASSERT_DEF(a_bit0_zero, out_valid_o |-> !read_data_o[0], "read data bit 0 set")
  `FMBSP_ASSERT_DEF(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled with free result register")
  `FMBSP_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_ready_o, "config port not ready")

endmodule

bind floor_mat_button_serial_port fmbsp_checker u_fmbsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o),
  .cfg_ready_o (cfg_ready_o)
);
